### rtl/mpsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsm_pkg
// Shared constants, codes and types of the multi-pattern substring matcher.
// ----------------------------------------------------------------------------
package mpsm_pkg;

  localparam int NUM_PATTERNS    = 16;
  localparam int MAX_PATTERN_LEN = 32;

  localparam int SLOT_W = $clog2(NUM_PATTERNS);
  localparam int CNT_W  = $clog2(NUM_PATTERNS + 1);
  localparam int POS_W  = $clog2(MAX_PATTERN_LEN);
  localparam int LEN_W  = $clog2(MAX_PATTERN_LEN + 1);
  localparam int ROW_W  = 8 * MAX_PATTERN_LEN;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_SCAN = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  localparam logic CFG_PICK_FIRST    = 1'b0;
  localparam logic CFG_PATTERN_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD_WR,
    ST_PASS,
    ST_EMIT
  } state_t;

endpackage

### rtl/mpsm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsm_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module mpsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/multi_pattern_substring_match_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pattern_substring_match_core
// Fixed-string matcher: a pattern table in RAM, one row per pattern, is
// compared against a window of the most recent haystack bytes, one row per
// cycle through a single compare unit.
// ----------------------------------------------------------------------------
// Load transaction: row read at accept, then merged row write.
// Haystack byte transaction: accept, then one pattern-RAM row read a cycle for
// each of the N active patterns (0..16), each row compared after its read.
// End of string (last byte or end command) adds the emit state, which waits
// there while the output register still holds an unaccepted result.
// Synchronous active-low reset sets pick-first, zeroes the pattern count and
// clears lengths, window, flags and counters; the pattern RAM is not cleared.
// ----------------------------------------------------------------------------
module multi_pattern_substring_match_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [3:0] in_slot,
  input  logic [4:0] in_pos,
  input  logic [7:0] in_byte_value,
  input  logic [5:0] in_length,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] out_match_index
);

  localparam int SLOT_W = mpsm_pkg::SLOT_W;
  localparam int CNT_W  = mpsm_pkg::CNT_W;
  localparam int POS_W  = mpsm_pkg::POS_W;
  localparam int LEN_W  = mpsm_pkg::LEN_W;
  localparam int ROW_W  = mpsm_pkg::ROW_W;
  localparam int NP     = mpsm_pkg::NUM_PATTERNS;
  localparam int ML     = mpsm_pkg::MAX_PATTERN_LEN;

  mpsm_pkg::state_t state_r, state_nxt;

  logic              pick_first_r;
  logic [4:0]        pattern_count_r;
  logic [LEN_W-1:0]  len_r [NP];
  logic [7:0]        recent_r [ML];
  logic [LEN_W-1:0]  bytes_seen_r;
  logic [NP-1:0]     found_r;

  logic [SLOT_W-1:0] slot_r;
  logic [POS_W-1:0]  pos_r;
  logic [7:0]        byte_r;
  logic              last_r;
  logic              cmp_en_r;
  logic [CNT_W-1:0]  rd_p_r;
  logic              cmp_v_r;
  logic [SLOT_W-1:0] cmp_p_r;
  logic [4:0]        idx_r;
  logic              out_valid_r;
  logic [4:0]        out_idx_r;

  logic              in_fire;
  logic              emit_fire;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_addr;
  logic [ROW_W-1:0]  ram_wdata;
  logic [ROW_W-1:0]  ram_rdata;
  logic [CNT_W-1:0]  n_act;
  logic              rd_more;
  logic              pass_done;
  logic [LEN_W-1:0]  cmp_len;
  logic              win_ok;
  logic              match;
  logic              hit;
  logic [LEN_W-1:0]  load_len;
  logic              slot_ok;
  logic              pos_ok;

  assign n_act = (pattern_count_r > 5'(NP)) ? CNT_W'(NP) : CNT_W'(pattern_count_r);
  assign rd_more   = (rd_p_r < n_act);
  assign pass_done = !rd_more && !cmp_v_r;
  assign load_len  = (in_length > 6'(ML)) ? LEN_W'(ML) : LEN_W'(in_length);
  assign slot_ok   = (32'(in_slot) < NP);
  assign pos_ok    = (32'(in_pos) < ML);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mpsm_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            mpsm_pkg::CMD_LOAD: begin
              if (slot_ok && pos_ok) state_nxt = mpsm_pkg::ST_LOAD_WR;
            end
            mpsm_pkg::CMD_SCAN, mpsm_pkg::CMD_END: state_nxt = mpsm_pkg::ST_PASS;
            default: state_nxt = mpsm_pkg::ST_IDLE;
          endcase
        end
      end
      mpsm_pkg::ST_LOAD_WR: state_nxt = mpsm_pkg::ST_IDLE;
      mpsm_pkg::ST_PASS: begin
        if (pass_done) state_nxt = last_r ? mpsm_pkg::ST_EMIT : mpsm_pkg::ST_IDLE;
      end
      mpsm_pkg::ST_EMIT: begin
        if (!out_valid_r || !out_stall) state_nxt = mpsm_pkg::ST_IDLE;
      end
      default: state_nxt = mpsm_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall  = 1'b1;
    emit_fire = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = in_slot;
    unique case (state_r)
      mpsm_pkg::ST_IDLE:    in_stall = 1'b0;
      mpsm_pkg::ST_LOAD_WR: begin
        ram_we   = 1'b1;
        ram_addr = slot_r;
      end
      mpsm_pkg::ST_PASS:    ram_addr = rd_p_r[SLOT_W-1:0];
      mpsm_pkg::ST_EMIT:    emit_fire = !out_valid_r || !out_stall;
      default:              in_stall = 1'b1;
    endcase
  end

  assign in_fire = in_valid && !in_stall;

  // Merge the loaded byte into the row read back from the table.
  always_comb begin
    ram_wdata = ram_rdata;
    for (int k = 0; k < ML; k++) begin
      if (pos_r == POS_W'(k)) ram_wdata[8*k +: 8] = byte_r;
    end
  end

  mpsm_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NP)
  ) u_pat_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // Shared compare unit: one pattern row against the window tail.
  always_comb begin
    cmp_len = len_r[cmp_p_r];
    win_ok  = 1'b1;
    for (int k = 0; k < ML; k++) begin
      if (LEN_W'(k) < cmp_len) begin
        if (ram_rdata[8*k +: 8] != recent_r[POS_W'(cmp_len - LEN_W'(1) - LEN_W'(k))]) begin
          win_ok = 1'b0;
        end
      end
    end
    match = cmp_en_r && ((cmp_len == '0) || ((bytes_seen_r >= cmp_len) && win_ok));
    hit   = found_r[cmp_p_r] || match || (cmp_len == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= mpsm_pkg::ST_IDLE;
      pick_first_r    <= 1'b1;
      pattern_count_r <= '0;
      for (int i = 0; i < NP; i++) len_r[i] <= '0;
      for (int i = 0; i < ML; i++) recent_r[i] <= '0;
      bytes_seen_r    <= '0;
      found_r         <= '0;
      last_r          <= 1'b0;
      cmp_en_r        <= 1'b0;
      rd_p_r          <= '0;
      cmp_v_r         <= 1'b0;
      idx_r           <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          mpsm_pkg::CFG_PICK_FIRST:    pick_first_r    <= cfg_wdata[0];
          mpsm_pkg::CFG_PATTERN_COUNT: pattern_count_r <= cfg_wdata;
          default:                     pick_first_r    <= pick_first_r;
        endcase
      end

      if (in_fire) begin
        unique case (in_cmd)
          mpsm_pkg::CMD_LOAD: begin
            if (slot_ok) len_r[in_slot] <= load_len;
          end
          mpsm_pkg::CMD_SCAN: begin
            recent_r[0] <= in_byte_value;
            for (int i = 1; i < ML; i++) recent_r[i] <= recent_r[i-1];
            if (bytes_seen_r < LEN_W'(ML)) bytes_seen_r <= bytes_seen_r + LEN_W'(1);
            last_r   <= in_last;
            cmp_en_r <= 1'b1;
            rd_p_r   <= '0;
            idx_r    <= '0;
          end
          mpsm_pkg::CMD_END: begin
            last_r   <= 1'b1;
            cmp_en_r <= 1'b0;
            rd_p_r   <= '0;
            idx_r    <= '0;
          end
          default: last_r <= last_r;
        endcase
      end

      // Issue one row read a cycle, compare it the cycle after.
      if (state_r == mpsm_pkg::ST_PASS) begin
        cmp_v_r <= rd_more;
        if (rd_more) rd_p_r <= rd_p_r + CNT_W'(1);
      end else begin
        cmp_v_r <= 1'b0;
      end

      if (cmp_v_r) begin
        if (match) found_r[cmp_p_r] <= 1'b1;
        if (last_r && hit && (!pick_first_r || idx_r == '0)) begin
          idx_r <= 5'(cmp_p_r) + 5'd1;
        end
      end

      if (emit_fire) begin
        out_valid_r  <= 1'b1;
        found_r      <= '0;
        bytes_seen_r <= '0;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      slot_r <= in_slot;
      pos_r  <= in_pos;
      byte_r <= in_byte_value;
    end
    if (state_r == mpsm_pkg::ST_PASS && rd_more) begin
      cmp_p_r <= rd_p_r[SLOT_W-1:0];
    end
    if (emit_fire) begin
      out_idx_r <= idx_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_index = out_idx_r;

  a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_v_r |-> (CNT_W'(cmp_p_r) < n_act))
    else $error("compare stage index beyond active patterns");

  a_rose_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == mpsm_pkg::ST_EMIT))
    else $error("result raised outside emit");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> (found_r == '0) && (bytes_seen_r == '0))
    else $error("flags or byte count not cleared at end of string");

  a_pass_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmp_v_r || ram_we) |-> in_stall)
    else $error("transaction accepted while table busy");

endmodule

### tb/multi_pattern_substring_match_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_pattern_substring_match_core_tb
// Self-checking bench for the fixed-string matcher. Pattern loads and haystack
// strings are driven over the valid/stall input channel. A scoreboard predicts
// the match index of every finished string and compares it with each result
// transaction. The run covers both report orders and several pattern counts,
// under sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module multi_pattern_substring_match_core_tb;

  localparam int NUM_PATTERNS    = mpsm_pkg::NUM_PATTERNS;
  localparam int MAX_PATTERN_LEN = mpsm_pkg::MAX_PATTERN_LEN;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 200;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PRINT_LIMIT  = 200;
  // Per-phase register settings, phase 0 in the low slot.
  localparam logic [PHASES-1:0]      PICK_SEQ  = 8'b1010_1010;
  localparam logic [PHASES-1:0][4:0] COUNT_SEQ =
    {5'd20, 5'd9, 5'd16, 5'd0, 5'd1, 5'd31, 5'd5, 5'd16};

  class match_scoreboard;
    logic [7:0]            row_bytes [NUM_PATTERNS][MAX_PATTERN_LEN];
    int unsigned           row_len   [NUM_PATTERNS];
    logic [7:0]            recent    [MAX_PATTERN_LEN];
    int unsigned           seen_cnt;
    bit [NUM_PATTERNS-1:0] hit;
    bit                    lowest_wins;
    int unsigned           count_cfg;
    logic [4:0]            expected_idx [$];
    int                    errors;

    function new();
      foreach (row_bytes[p, k]) row_bytes[p][k] = 8'h00;
      foreach (row_len[p]) row_len[p] = 0;
      foreach (recent[k]) recent[k] = 8'h00;
      seen_cnt    = 0;
      hit         = '0;
      lowest_wins = 1'b1;
      count_cfg   = 0;
      errors      = 0;
    endfunction

    function void write_reg(logic idx, logic [4:0] val);
      if (idx == mpsm_pkg::CFG_PICK_FIRST) lowest_wins = val[0];
      else count_cfg = val;
    endfunction

    function int unsigned active();
      return (count_cfg > NUM_PATTERNS) ? NUM_PATTERNS : count_cfg;
    endfunction

    function int pending();
      return expected_idx.size();
    endfunction

    // Pattern p sits at the tail of the window, oldest byte first.
    function bit tail_hit(int unsigned p);
      if (row_len[p] == 0) return 1'b1;
      if (seen_cnt < row_len[p]) return 1'b0;
      for (int unsigned k = 0; k < row_len[p]; k++)
        if (row_bytes[p][k] != recent[row_len[p] - 1 - k]) return 1'b0;
      return 1'b1;
    endfunction

    function logic [4:0] close_string();
      int unsigned winner;
      winner = 0;
      for (int unsigned p = 0; p < active(); p++) begin
        if (hit[p] || row_len[p] == 0) begin
          winner = p + 1;
          if (lowest_wins) break;
        end
      end
      hit      = '0;
      seen_cnt = 0;
      return winner[4:0];
    endfunction

    function void note_input(logic [1:0] cmd, logic [3:0] slot, logic [4:0] pos,
                             logic [7:0] bval, logic [5:0] len, logic last);
      case (cmd)
        mpsm_pkg::CMD_LOAD: begin
          row_bytes[slot][pos] = bval;
          row_len[slot] = (len > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : len;
        end
        mpsm_pkg::CMD_SCAN: begin
          for (int k = MAX_PATTERN_LEN - 1; k > 0; k--) recent[k] = recent[k - 1];
          recent[0] = bval;
          if (seen_cnt < MAX_PATTERN_LEN) seen_cnt++;
          for (int unsigned p = 0; p < active(); p++)
            if (tail_hit(p)) hit[p] = 1'b1;
          if (last) expected_idx.push_back(close_string());
        end
        mpsm_pkg::CMD_END: expected_idx.push_back(close_string());
        default: ;
      endcase
    endfunction

    function void check_result(logic [4:0] got);
      logic [4:0] want;
      if (expected_idx.size() == 0) begin
        if (errors < PRINT_LIMIT)
          $display("%0t: match_index expected none, actual %0d", $time, got);
        errors++;
        return;
      end
      want = expected_idx.pop_front();
      if (got !== want) begin
        if (errors < PRINT_LIMIT)
          $display("%0t: match_index expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [4:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_cmd;
  logic [3:0] in_slot;
  logic [4:0] in_pos;
  logic [7:0] in_byte_value;
  logic [5:0] in_length;
  logic       in_last;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [4:0] out_match_index;

  int          idle_pct  = 0;
  int          stall_pct = 0;
  int          items_sent = 0;
  int unsigned cycle_cnt = 0;
  match_scoreboard sb;

  // Bench-side copy of what has been loaded, used to build haystacks and to
  // keep every active pattern fully written.
  logic [7:0]               shadow_row     [NUM_PATTERNS][MAX_PATTERN_LEN];
  bit [MAX_PATTERN_LEN-1:0] shadow_written [NUM_PATTERNS];
  int unsigned              shadow_len     [NUM_PATTERNS];

  multi_pattern_substring_match_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_slot         (in_slot),
    .in_pos          (in_pos),
    .in_byte_value   (in_byte_value),
    .in_length       (in_length),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match_index (out_match_index)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_match_index);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL multi_pattern_substring_match_core");
      $finish;
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1:    return 8'h00;
      2, 3:    return 8'hFF;
      4, 5:    return 8'h61;
      6:       return 8'h62;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int unsigned written_prefix(int unsigned slot);
    int unsigned n;
    n = 0;
    while (n < MAX_PATTERN_LEN && shadow_written[slot][n]) n++;
    return n;
  endfunction

  // Valid stays up between back-to-back transactions; it drops only on a gap.
  task automatic push_item(input logic [1:0] cmd, input logic [3:0] slot,
                           input logic [4:0] pos, input logic [7:0] bval,
                           input logic [5:0] len, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_slot       <= slot;
    in_pos        <= pos;
    in_byte_value <= bval;
    in_length     <= len;
    in_last       <= last;
    do @(posedge clk); while (in_stall);
    sb.note_input(cmd, slot, pos, bval, len, last);
    if (cmd != CMD_UNUSED) items_sent++;
    if (cmd == mpsm_pkg::CMD_LOAD) begin
      shadow_row[slot][pos]     = bval;
      shadow_written[slot][pos] = 1'b1;
      shadow_len[slot]          = (len > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : len;
    end
  endtask

  task automatic push_load(input int unsigned slot, input int unsigned pos,
                           input logic [7:0] bval, input logic [5:0] len);
    push_item(mpsm_pkg::CMD_LOAD, 4'(slot), 5'(pos), bval, len, 1'($urandom));
  endtask

  task automatic push_scan(input logic [7:0] bval, input logic last);
    push_item(mpsm_pkg::CMD_SCAN, 4'($urandom), 5'($urandom), bval, 6'($urandom), last);
  endtask

  task automatic push_end();
    push_item(mpsm_pkg::CMD_END, 4'($urandom), 5'($urandom), 8'($urandom),
              6'($urandom), 1'($urandom));
  endtask

  task automatic push_junk();
    push_item(CMD_UNUSED, 4'($urandom), 5'($urandom), 8'($urandom), 6'($urandom),
              1'($urandom));
  endtask

  // Write bytes in order; each load raises the length only over written bytes.
  task automatic load_pattern(input int unsigned slot, input int unsigned plen);
    for (int unsigned k = 0; k < plen; k++)
      push_load(slot, k, pick_byte(),
                (k == MAX_PATTERN_LEN - 1) ? 6'($urandom_range(32, 63)) : 6'(k + 1));
    if (plen == 0) push_load(slot, $urandom_range(0, MAX_PATTERN_LEN - 1),
                             pick_byte(), 6'd0);
  endtask

  task automatic noise_load();
    int unsigned slot, pos, room;
    slot = $urandom_range(0, NUM_PATTERNS - 1);
    pos  = $urandom_range(0, MAX_PATTERN_LEN - 1);
    shadow_written[slot][pos] = 1'b1;
    room = written_prefix(slot);
    push_load(slot, pos, 8'($urandom),
              (room == MAX_PATTERN_LEN) ? 6'($urandom_range(0, 63))
                                        : 6'($urandom_range(0, room)));
  endtask

  task automatic scan_string();
    logic [7:0]  text [$];
    int unsigned s, n, cut, at;
    bit          end_by_cmd;
    case ($urandom_range(0, 9))
      0:       n = 0;
      1:       n = $urandom_range(33, 40);
      default: n = $urandom_range(1, 10);
    endcase
    for (int unsigned k = 0; k < n; k++) text.push_back(pick_byte());
    // Embed a loaded pattern, sometimes cut short for a near miss.
    if ($urandom_range(0, 9) < 6) begin
      s   = $urandom_range(0, 1) ? $urandom_range(0, 4)
                                 : $urandom_range(0, NUM_PATTERNS - 1);
      cut = shadow_len[s];
      if (cut > 0 && $urandom_range(0, 4) == 0) cut--;
      at  = $urandom_range(0, text.size());
      for (int unsigned k = 0; k < cut; k++) text.insert(at + k, shadow_row[s][k]);
    end
    end_by_cmd = (text.size() == 0) || ($urandom_range(0, 9) == 0);
    foreach (text[k]) push_scan(text[k], !end_by_cmd && k == text.size() - 1);
    if (end_by_cmd) push_end();
  endtask

  // Drop valid, wait for every expected result, then let the core go idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(input logic pick, input logic [4:0] count);
    logic [4:0] pick_word;
    pick_word = {4'($urandom), pick};
    cfg_we    <= 1'b1;
    cfg_index <= mpsm_pkg::CFG_PICK_FIRST;
    cfg_wdata <= pick_word;
    @(posedge clk);
    sb.write_reg(mpsm_pkg::CFG_PICK_FIRST, pick_word);
    cfg_index <= mpsm_pkg::CFG_PATTERN_COUNT;
    cfg_wdata <= count;
    @(posedge clk);
    sb.write_reg(mpsm_pkg::CFG_PATTERN_COUNT, count);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int target, r;
    bit paused;
    sb = new();
    foreach (shadow_row[p, k]) shadow_row[p][k] = 8'h00;
    foreach (shadow_written[p]) shadow_written[p] = '0;
    foreach (shadow_len[p]) shadow_len[p] = 0;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= mpsm_pkg::CFG_PICK_FIRST;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_cmd        <= mpsm_pkg::CMD_LOAD;
    in_slot       <= '0;
    in_pos        <= '0;
    in_byte_value <= '0;
    in_length     <= '0;
    in_last       <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: no active patterns, so every string reports zero.
    push_end();
    push_scan(8'h41, 1'b1);
    settle();

    // Oversized count acts as all patterns; highest match wins.
    apply_config(1'b0, 5'd31);
    push_load(15, 0, 8'hFF, 6'd1);
    push_load(15, 1, 8'h00, 6'd2);
    push_load(0, 0, 8'h00, 6'd0);
    push_scan(8'hFF, 1'b0);
    push_junk();
    push_scan(8'h00, 1'b1);
    push_end();
    push_load(7, MAX_PATTERN_LEN - 1, 8'hAA, 6'd0);
    push_scan(8'h12, 1'b0);
    push_end();
    settle();
    apply_config(1'b1, 5'd16);
    push_scan(8'h00, 1'b1);
    push_end();

    // Give every slot a short pattern so empty slots do not hide the rest.
    for (int unsigned s = 0; s < NUM_PATTERNS; s++)
      load_pattern(s, $urandom_range(1, 4));

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      apply_config(PICK_SEQ[ph], COUNT_SEQ[ph]);
      case (ph % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 65; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 65; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      target = items_sent + PHASE_ITEMS;
      paused = 1'b0;
      while (items_sent < target) begin
        // Hold the sender mid-phase until the core has fully caught up.
        if (!paused && items_sent >= target - PHASE_ITEMS / 2) begin
          settle();
          paused = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 12) begin
          case ($urandom_range(0, 19))
            0:       load_pattern($urandom_range(0, NUM_PATTERNS - 1), 0);
            1, 2:    load_pattern($urandom_range(0, NUM_PATTERNS - 1), MAX_PATTERN_LEN);
            3, 4, 5, 6:
                     load_pattern($urandom_range(0, NUM_PATTERNS - 1),
                                  $urandom_range(5, 12));
            default: load_pattern($urandom_range(0, NUM_PATTERNS - 1),
                                  $urandom_range(1, 4));
          endcase
        end else if (r < 18) begin
          noise_load();
        end else if (r < 22) begin
          push_junk();
        end else begin
          scan_string();
        end
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("PASS multi_pattern_substring_match_core");
    end else begin
      $display("FAIL multi_pattern_substring_match_core");
    end
    $finish;
  end

endmodule
